// ===== hdl/wsg_pkg.sv =====
// Package for the wavetable sound generator: constants, register group codes and control structs.
package wsg_pkg;

    localparam int CHANNELS    = 5;
    localparam int WAVE_LEN    = 32;
    localparam int PHASE_SHIFT = 16;
    localparam logic [31:0] STEP_BASE = 32'd458178;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COL_W      = $clog2(WAVE_LEN);
    localparam int WAVE_DEPTH = CHANNELS * WAVE_LEN;
    localparam int WAVE_AW    = $clog2(WAVE_DEPTH);
    localparam int MIX_W      = 12;

    localparam int QUOT_W     = 32;
    localparam int DIV_CNT_W  = $clog2(QUOT_W);
    localparam int PER_W      = 12;
    localparam int DEN_W      = PER_W + 1;
    localparam int MIN_DIVISOR = 9;

    localparam logic signed [MIX_W-1:0] MIX_MAX = 127;
    localparam logic signed [MIX_W-1:0] MIX_MIN = -128;

    localparam int WAVE_LOCK_BIT = 6;

    localparam logic [6:0] GRP_WAVE_A = 7'd0;
    localparam logic [6:0] GRP_FREQ   = 7'd1;
    localparam logic [6:0] GRP_VOL    = 7'd2;
    localparam logic [6:0] GRP_KEY    = 7'd3;
    localparam logic [6:0] GRP_WAVE_B = 7'd4;
    localparam logic [6:0] GRP_TEST   = 7'd5;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic bus_exec;
        logic div_step;
        logic ren_start;
        logic ren_acc;
        logic ren_mac;
        logic ren_out;
    } cmd_t;

    typedef struct packed {
        logic clr_busy;
        logic clr_last;
        logic is_render;
        logic div_need;
        logic div_last;
        logic ch_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/wsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/wsg_ctrl.sv =====
// Sequencer for the wavetable sound generator: clear pass, bus writes, divide, render.
module wsg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output wsg_pkg::cmd_t cmd,
    input  wsg_pkg::sts_t sts
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_MAC   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_render)
                begin
                    cmd.ren_start = 1'b1;
                    state_next    = ST_ACC;
                end
                else
                begin
                    cmd.bus_exec = 1'b1;
                    state_next   = sts.div_need ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                cmd.ren_acc = 1'b1;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.ren_mac = 1'b1;
                state_next  = sts.ch_last ? ST_OUT : ST_ACC;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.ren_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/wsg_datapath.sv =====
// Datapath: channel registers, wave RAM, restoring divider, mixer and output register.
module wsg_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  wsg_pkg::cmd_t cmd,
    output wsg_pkg::sts_t sts,
    input  logic [15:0]   s_axis_tdata,
    input  logic          s_axis_tuser,
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready
);

    localparam int CH  = wsg_pkg::CHANNELS;
    localparam int CHW = wsg_pkg::CH_W;
    localparam int PS  = wsg_pkg::PHASE_SHIFT;
    localparam int CW  = wsg_pkg::COL_W;
    localparam int AW  = wsg_pkg::WAVE_AW;
    localparam int MW  = wsg_pkg::MIX_W;
    localparam int DW  = wsg_pkg::DEN_W;
    localparam int QW  = wsg_pkg::QUOT_W;
    localparam int NW  = wsg_pkg::DIV_CNT_W;

    // architectural state
    logic [31:0]             acc_reg    [CH];
    logic [31:0]             acc_next   [CH];
    logic [31:0]             step_reg   [CH];
    logic [31:0]             step_next  [CH];
    logic [wsg_pkg::PER_W-1:0] period_reg [CH];
    logic [wsg_pkg::PER_W-1:0] period_next[CH];
    logic [3:0]              vol_reg    [CH];
    logic [3:0]              vol_next   [CH];
    logic [CH-1:0]           key_reg, key_next;
    logic [7:0]              addr_reg, addr_next;
    logic [7:0]              test_reg, test_next;

    // sequencing
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                    clr_busy_reg, clr_busy_next;
    logic [CHW-1:0]          ch_reg, ch_next;
    logic                    out_valid_reg, out_valid_next;

    // payload
    logic                    type_reg, type_next;
    logic [7:0]              port_reg, port_next;
    logic [7:0]              data_reg, data_next;
    logic                    active_reg, active_next;
    logic signed [MW-1:0]    mix_reg, mix_next;
    logic [NW-1:0]           div_cnt_reg, div_cnt_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [QW-1:0]           dvd_reg, dvd_next;
    logic [DW-1:0]           den_reg, den_next;
    logic [CHW-1:0]          div_ch_reg, div_ch_next;
    logic [7:0]              out_data_reg, out_data_next;

    // wave RAM
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [7:0]              ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [7:0]              ram_rdata;

    // decode
    logic [6:0]              grp;
    logic                    is_data;
    logic [3:0]              row_ext;
    logic                    row_ok;
    logic [6:0]              fch;
    logic                    fch_ok;
    logic [CHW-1:0]          fidx;
    logic [3:0]              vch_ext;
    logic                    vch_ok;
    logic [wsg_pkg::PER_W-1:0] new_per;
    logic [DW-1:0]           den;
    logic                    den_big;
    logic [31:0]             acc_sum;
    logic [DW:0]             rem_sh;
    logic                    q_bit;
    logic [7:0]              mag;
    logic [11:0]             prod;
    logic [MW-1:0]           term;
    logic [7:0]              sat;

    assign grp     = port_reg[7:1];
    assign is_data = port_reg[0];
    assign row_ext = {1'b0, addr_reg[7:5]};
    assign row_ok  = row_ext < 4'(CH);
    assign fch     = addr_reg[7:1];
    assign fch_ok  = fch < 7'(CH);
    assign fidx    = fch[CHW-1:0];
    assign vch_ext = {1'b0, addr_reg[2:0]};
    assign vch_ok  = vch_ext < 4'(CH);

    always_comb
    begin
        new_per = period_reg[fidx];
        if (addr_reg[0])
        begin
            new_per[11:8] = data_reg[3:0];
        end
        else
        begin
            new_per[7:0] = data_reg;
        end
    end

    assign den     = {1'b0, new_per} + DW'(1);
    assign den_big = den >= DW'(wsg_pkg::MIN_DIVISOR);

    assign acc_sum = acc_reg[ch_reg] + step_reg[ch_reg];

    assign rem_sh  = {rem_reg, dvd_reg[QW-1]};
    assign q_bit   = rem_sh >= {1'b0, den_reg};

    assign mag  = ram_rdata[7] ? 8'(9'd256 - {1'b0, ram_rdata}) : ram_rdata;
    assign prod = mag * vol_reg[ch_reg];
    assign term = {{(MW-8){1'b0}}, prod[11:4]};

    always_comb
    begin
        if (mix_reg > wsg_pkg::MIX_MAX)
        begin
            sat = 8'hFF;
        end
        else if (mix_reg < wsg_pkg::MIX_MIN)
        begin
            sat = 8'h00;
        end
        else
        begin
            sat = mix_reg[7:0] ^ 8'h80;
        end
    end

    assign ram_raddr = AW'({ch_reg, acc_sum[PS+CW-1:PS]});

    always_comb
    begin
        acc_next       = acc_reg;
        step_next      = step_reg;
        period_next    = period_reg;
        vol_next       = vol_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        test_next      = test_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_busy_next  = clr_busy_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        type_next      = type_reg;
        port_next      = port_reg;
        data_next      = data_reg;
        active_next    = active_reg;
        mix_next       = mix_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        den_next       = den_reg;
        div_ch_next    = div_ch_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'({addr_reg[7:5], addr_reg[4:0]});
        ram_wdata      = data_reg;

        if (cmd.clr_step)
        begin
            ram_we       = 1'b1;
            ram_waddr    = clr_cnt_reg;
            ram_wdata    = 8'h00;
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (sts.clr_last)
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (cmd.load)
        begin
            type_next = s_axis_tuser;
            port_next = s_axis_tdata[7:0];
            data_next = s_axis_tdata[15:8];
        end

        if (cmd.bus_exec)
        begin
            if (!is_data)
            begin
                addr_next = data_reg;
            end
            else
            begin
                case (grp)
                    wsg_pkg::GRP_WAVE_A, wsg_pkg::GRP_WAVE_B:
                    begin
                        if (!test_reg[wsg_pkg::WAVE_LOCK_BIT] && row_ok)
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    wsg_pkg::GRP_FREQ:
                    begin
                        if (fch_ok)
                        begin
                            period_next[fidx] = new_per;
                            if (!den_big)
                            begin
                                step_next[fidx] = '0;
                            end
                            div_cnt_next = '0;
                            rem_next     = '0;
                            dvd_next     = wsg_pkg::STEP_BASE;
                            den_next     = den;
                            div_ch_next  = fidx;
                        end
                    end
                    wsg_pkg::GRP_VOL:
                    begin
                        if (vch_ok)
                        begin
                            vol_next[vch_ext[CHW-1:0]] = data_reg[3:0];
                        end
                    end
                    wsg_pkg::GRP_KEY:
                    begin
                        key_next = data_reg[CH-1:0];
                    end
                    wsg_pkg::GRP_TEST:
                    begin
                        test_next = data_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cmd.div_step)
        begin
            rem_next     = q_bit ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            dvd_next     = {dvd_reg[QW-2:0], q_bit};
            div_cnt_next = div_cnt_reg + NW'(1);
            if (sts.div_last)
            begin
                step_next[div_ch_reg] = {dvd_reg[QW-2:0], q_bit};
            end
        end

        if (cmd.ren_start)
        begin
            ch_next  = '0;
            mix_next = '0;
        end

        if (cmd.ren_acc)
        begin
            if (step_reg[ch_reg] != 32'd0)
            begin
                acc_next[ch_reg] = acc_sum;
            end
            active_next = (step_reg[ch_reg] != 32'd0) && key_reg[ch_reg];
        end

        if (cmd.ren_mac)
        begin
            if (active_reg)
            begin
                mix_next = ram_rdata[7] ? mix_reg - $signed(term) : mix_reg + $signed(term);
            end
            ch_next = ch_reg + CHW'(1);
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.ren_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '{default: '0};
            step_reg      <= '{default: '0};
            period_reg    <= '{default: '0};
            vol_reg       <= '{default: '0};
            key_reg       <= '0;
            addr_reg      <= '0;
            test_reg      <= '0;
            clr_cnt_reg   <= '0;
            clr_busy_reg  <= 1'b1;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            period_reg    <= period_next;
            vol_reg       <= vol_next;
            key_reg       <= key_next;
            addr_reg      <= addr_next;
            test_reg      <= test_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_busy_reg  <= clr_busy_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        port_reg     <= port_next;
        data_reg     <= data_next;
        active_reg   <= active_next;
        mix_reg      <= mix_next;
        div_cnt_reg  <= div_cnt_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        den_reg      <= den_next;
        div_ch_reg   <= div_ch_next;
        out_data_reg <= out_data_next;
    end

    wsg_ram #(
        .WIDTH (8),
        .DEPTH (wsg_pkg::WAVE_DEPTH)
    ) u_wave_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.clr_busy  = clr_busy_reg;
    assign sts.clr_last  = clr_cnt_reg == AW'(wsg_pkg::WAVE_DEPTH - 1);
    assign sts.is_render = type_reg;
    assign sts.div_need  = is_data && (grp == wsg_pkg::GRP_FREQ) && fch_ok && den_big;
    assign sts.div_last  = div_cnt_reg == NW'(QW - 1);
    assign sts.ch_last   = ch_reg == CHW'(CH - 1);
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hdl/wavetable_sound_generator_core.sv =====
// Top level of the five-channel wavetable sound generator.
// One input beat is either a bus write (tuser low) or a render request (tuser high). The block
// takes one beat at a time. A frequency write whose divisor is 9 or more also runs the
// radix-2 divider, which forms one of the 32 phase-step bits a cycle. A render steps through an
// accumulate and a multiply-accumulate state for each channel over the shared wave RAM read port,
// and its sample sits in an output register so the next beat is taken while it waits. After
// reset the wave RAM is zeroed, during which s_axis_tready stays low.
module wavetable_sound_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] port, [15:8] wdata
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] sample
);

    wsg_pkg::cmd_t cmd;
    wsg_pkg::sts_t sts;

    wsg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    wsg_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ren_out |-> sts.out_free)
        else $error("sample loaded over a pending beat");

    a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.clr_busy)
        else $error("input taken during wave RAM clear");

    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(cmd.div_step || cmd.ren_acc || cmd.ren_mac || cmd.bus_exec))
        else $error("input ready while work in progress");

    a_div_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_last) |=> s_axis_tready)
        else $error("divider finish did not return to idle");

endmodule

// ===== dv/wsg_sample_checker.sv =====
`timescale 1ns / 1ps
// Checker for the wavetable sound generator: predicts each mixed sample and compares output beats.
module wsg_sample_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] port, [15:8] wdata
    input  logic        s_axis_tuser,   // [0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] sample
    output int          mismatches,
    output int          pending
);

    logic [31:0] acc    [wsg_pkg::CHANNELS];
    logic [31:0] step   [wsg_pkg::CHANNELS];
    logic [11:0] period [wsg_pkg::CHANNELS];
    logic [3:0]  vol    [wsg_pkg::CHANNELS];
    logic        keyed  [wsg_pkg::CHANNELS];
    logic [7:0]  wave   [wsg_pkg::CHANNELS][wsg_pkg::WAVE_LEN];
    logic [7:0]  addr_reg;
    logic [7:0]  test_reg;
    logic [7:0]  samples_due[$];
    logic [7:0]  sample_want;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_voices();
        for (int ch = 0; ch < wsg_pkg::CHANNELS; ch++)
        begin
            acc[ch]    = '0;
            step[ch]   = '0;
            period[ch] = '0;
            vol[ch]    = '0;
            keyed[ch]  = 1'b0;
            for (int col = 0; col < wsg_pkg::WAVE_LEN; col++)
                wave[ch][col] = '0;
        end
        addr_reg = '0;
        test_reg = '0;
    endfunction

    function automatic void write_register(logic [7:0] port, logic [7:0] d);
        logic [6:0]  grp;
        logic [31:0] divisor;
        int          ch;
        if (!port[0])
        begin
            addr_reg = d;
            return;
        end
        grp = port[7:1];
        case (grp)
            wsg_pkg::GRP_WAVE_A, wsg_pkg::GRP_WAVE_B:
            begin
                if (!test_reg[wsg_pkg::WAVE_LOCK_BIT]
                    && int'(addr_reg[7:5]) < wsg_pkg::CHANNELS)
                    wave[addr_reg[7:5]][addr_reg[wsg_pkg::COL_W-1:0]] = d;
            end
            wsg_pkg::GRP_FREQ:
            begin
                ch = int'(addr_reg[7:1]);
                if (ch < wsg_pkg::CHANNELS)
                begin
                    if (addr_reg[0])
                        period[ch][11:8] = d[3:0];
                    else
                        period[ch][7:0] = d;
                    divisor = 32'(period[ch]) + 32'd1;
                    step[ch] = (divisor < wsg_pkg::MIN_DIVISOR) ? 32'd0
                                                                : wsg_pkg::STEP_BASE / divisor;
                end
            end
            wsg_pkg::GRP_VOL:
            begin
                ch = int'(addr_reg[2:0]);
                if (ch < wsg_pkg::CHANNELS)
                    vol[ch] = d[3:0];
            end
            wsg_pkg::GRP_KEY:
            begin
                for (int c = 0; c < wsg_pkg::CHANNELS; c++)
                    keyed[c] = d[c];
            end
            wsg_pkg::GRP_TEST:
                test_reg = d;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] render_sample();
        int          mix;
        int          b;
        logic [31:0] shifted;
        mix = 0;
        for (int ch = 0; ch < wsg_pkg::CHANNELS; ch++)
        begin
            if (step[ch] != 0)
            begin
                acc[ch] = acc[ch] + step[ch];
                if (keyed[ch])
                begin
                    shifted = acc[ch] >> wsg_pkg::PHASE_SHIFT;
                    b = int'(wave[ch][shifted[wsg_pkg::COL_W-1:0]]);
                    // sign-magnitude scaling, magnitude truncated toward zero
                    if (b >= 128)
                        mix -= ((256 - b) * int'(vol[ch])) >>> 4;
                    else
                        mix += (b * int'(vol[ch])) >>> 4;
                end
            end
        end
        if (mix > int'(wsg_pkg::MIX_MAX))
            mix = int'(wsg_pkg::MIX_MAX);
        if (mix < int'(wsg_pkg::MIX_MIN))
            mix = int'(wsg_pkg::MIX_MIN);
        return 8'(mix + 128);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_voices();
            samples_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // drain first: a sample leaving now belongs to an earlier render
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (samples_due.size() == 0)
                    report_mismatch($sformatf("sample 0x%02h with none pending", m_axis_tdata));
                else
                begin
                    sample_want = samples_due.pop_front();
                    if (m_axis_tdata !== sample_want)
                        report_mismatch($sformatf("sample 0x%02h, want 0x%02h",
                                                  m_axis_tdata, sample_want));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                    samples_due.push_back(render_sample());
                else
                    write_register(s_axis_tdata[7:0], s_axis_tdata[15:8]);
            end
            pending = samples_due.size();
        end
    end

endmodule

// ===== dv/tb_wavetable_sound_generator_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the wavetable sound generator core: clock, reset, beat stimulus and verdict.
module tb_wavetable_sound_generator_core;

    localparam int ITEM_TARGET  = 1300;
    // covers the wave RAM clear after reset, the divides and long random stalls
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic       REQ_WRITE  = 1'b0;
    localparam logic       REQ_RENDER = 1'b1;
    localparam logic [7:0] PORT_WAVE     = {wsg_pkg::GRP_WAVE_A, 1'b1};
    localparam logic [7:0] PORT_WAVE_ALT = {wsg_pkg::GRP_WAVE_B, 1'b1};
    localparam logic [7:0] PORT_FREQ     = {wsg_pkg::GRP_FREQ, 1'b1};
    localparam logic [7:0] PORT_VOL      = {wsg_pkg::GRP_VOL, 1'b1};
    localparam logic [7:0] PORT_KEY      = {wsg_pkg::GRP_KEY, 1'b1};
    localparam logic [7:0] PORT_TEST     = {wsg_pkg::GRP_TEST, 1'b1};
    localparam logic [7:0] TEST_WAVE_LOCK = 8'h40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    int mismatches;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;
    int quiet_cycles = 0;

    wavetable_sound_generator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wsg_sample_checker sample_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic req, input logic [7:0] port, input logic [7:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {d, port};
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] addr, input logic [7:0] port,
                             input logic [7:0] d);
        send_beat(REQ_WRITE, {7'($urandom_range(0, 127)), 1'b0}, addr);
        send_beat(REQ_WRITE, port, d);
    endtask

    task automatic render_burst(input int n);
        repeat (n) send_beat(REQ_RENDER, 8'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(input int stop_at);
        int         pick;
        logic       hi;
        logic [7:0] addr;
        logic [7:0] d;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                render_burst($urandom_range(1, 8));
            else if (pick < 72)
            begin
                addr[4:0] = 5'($urandom);
                addr[7:5] = ($urandom_range(0, 9) == 0)
                            ? 3'($urandom_range(wsg_pkg::CHANNELS, 7))
                            : 3'($urandom_range(0, wsg_pkg::CHANNELS - 1));
                case ($urandom_range(0, 4))
                    0: d = 8'h7F;
                    1: d = 8'h80;
                    2: d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
                write_reg(addr, $urandom_range(0, 1) ? PORT_WAVE : PORT_WAVE_ALT, d);
            end
            else if (pick < 82)
            begin
                hi = 1'($urandom);
                addr = ($urandom_range(0, 7) == 0)
                       ? 8'($urandom)
                       : {7'($urandom_range(0, wsg_pkg::CHANNELS - 1)), hi};
                // mostly keep the low nibble clear on high-part writes so the phase moves quickly
                d = (addr[0] && $urandom_range(0, 3) != 0) ? (8'($urandom) & 8'hF0)
                                                           : 8'($urandom);
                write_reg(addr, PORT_FREQ, d);
            end
            else if (pick < 88)
                write_reg(8'($urandom), PORT_VOL, 8'($urandom));
            else if (pick < 92)
                send_beat(REQ_WRITE, PORT_KEY,
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF);
            else if (pick < 95)
            begin
                case ($urandom_range(0, 3))
                    0: d = TEST_WAVE_LOCK;
                    1: d = 8'($urandom);
                    default: d = 8'h00;
                endcase
                send_beat(REQ_WRITE, PORT_TEST, d);
            end
            else
                send_beat(REQ_WRITE, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 31;
        recv_idle_pct = 66;
        beats_sent    = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        render_burst(1);                          // silence after reset
        write_reg(8'h00, PORT_WAVE, 8'h7F);
        write_reg(8'h00, PORT_FREQ, 8'h07);       // divisor 8: step stays zero
        send_beat(REQ_WRITE, PORT_FREQ, 8'h08);   // divisor 9: smallest live step
        write_reg(8'h00, PORT_VOL, 8'hFF);
        send_beat(REQ_WRITE, PORT_KEY, 8'hFF);
        render_burst(2);
        write_reg(8'h09, PORT_FREQ, 8'hFF);       // high part of the last channel
        write_reg(8'h0A, PORT_FREQ, 8'h10);       // channel out of range
        write_reg(8'h07, PORT_VOL, 8'h0F);        // channel out of range
        write_reg(8'hA0, PORT_WAVE_ALT, 8'hFF);   // wave row past the last channel
        send_beat(REQ_WRITE, PORT_TEST, TEST_WAVE_LOCK);
        write_reg(8'h00, PORT_WAVE, 8'h80);       // dropped while locked
        send_beat(REQ_WRITE, PORT_TEST, 8'h00);
        send_beat(REQ_WRITE, 8'hFF, 8'h55);       // unused group
        render_burst(1);

        random_traffic(ITEM_TARGET / 3);
        send_idle_pct = 66;
        recv_idle_pct = 31;
        random_traffic(2 * ITEM_TARGET / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(ITEM_TARGET);
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wsg_pkg.sv
hdl/wsg_ram.sv
hdl/wsg_ctrl.sv
hdl/wsg_datapath.sv
hdl/wavetable_sound_generator_core.sv
dv/wsg_sample_checker.sv
dv/tb_wavetable_sound_generator_core.sv
